@@ rtl/core/hkrt_pkg.sv @@
// ----------------------------------------------------------------------------
// hkrt_pkg
// Shared types, sizes and action codes of the key rollover table.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrt_pkg;

  localparam int MAX_KEYS   = 6;
  localparam int KEY_W      = 8;
  localparam int ACTION_W   = 3;
  localparam int SLOT_W     = 4;

  // Both report formats start with two zero bytes; the key field follows.
  localparam int KEY_POS    = 2;
  localparam int TABLE_LEN  = KEY_POS + MAX_KEYS;
  localparam int SINGLE_LEN = 8;
  localparam int REPORT_MAX = (TABLE_LEN > SINGLE_LEN) ? TABLE_LEN : SINGLE_LEN;
  localparam int CNT_W      = $clog2(REPORT_MAX);
  localparam int IDX_W      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD         = 3'd0,
    ACT_REMOVE      = 3'd1,
    ACT_LOOKUP      = 3'd2,
    ACT_CLEAR       = 3'd3,
    ACT_SEND_TABLE  = 3'd4,
    ACT_SEND_SINGLE = 3'd5
  } action_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } search_t;

  // Lowest set bit of a per-slot match vector.
  function automatic search_t first_set(input logic [MAX_KEYS-1:0] v);
    search_t r;
    r = '0;
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = SLOT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hkrt_cmd_if.sv @@
// ----------------------------------------------------------------------------
// hkrt_cmd_if
// Command channel: one action and one key code per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkrt_cmd_if;
  import hkrt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key_code;

  modport source (output valid, output action, output key_code, input ready);
  modport sink   (input valid, input action, input key_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hkrt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hkrt_rsp_if
// Result channel: a status word or one byte of a keyboard report per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkrt_rsp_if;
  import hkrt_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_report;
  logic              ok;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  report_byte;
  logic              last;

  modport source (output valid, output is_report, output ok, output slot,
                  output report_byte, output last, input ready);
  modport sink   (input valid, input is_report, input ok, input slot,
                  input report_byte, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hid_key_rollover_table.sv @@
// ----------------------------------------------------------------------------
// hid_key_rollover_table
// Table of held key codes with boot keyboard report generation.
// ----------------------------------------------------------------------------
// Add, remove, lookup and clear each return one status word; a new command
// is accepted every cycle while the result register is free or being
// drained. The two send commands stream their report one byte per cycle
// through the same result register while its bytes are taken: a table
// report is 2 + MAX_KEYS bytes and a single-key report 8 bytes long, and
// while one streams no new command is accepted. Action codes six and seven
// are taken and dropped with no result. All slot searches are one parallel
// compare over the table and take the lowest matching slot, so a search for
// code zero hits the first empty slot and adding code zero is always refused.
`default_nettype none

module hid_key_rollover_table (
  input  wire          clk,
  input  wire          rst,
  hkrt_cmd_if.sink     cmd,
  hkrt_rsp_if.source   rsp
);
  import hkrt_pkg::*;

  key_t              slots [MAX_KEYS];
  logic              busy;
  logic              is_single;
  logic [CNT_W-1:0]  cnt;
  key_t              single_key;

  logic              o_valid;
  logic              o_is_report;
  logic              o_ok;
  logic [SLOT_W-1:0] o_slot;
  key_t              o_byte;
  logic              o_last;

  logic              out_free;
  logic              accept;
  logic [MAX_KEYS-1:0] hit;
  logic [MAX_KEYS-1:0] empty;
  search_t           hit_s;
  search_t           empty_s;

  logic              st_valid;
  logic              st_ok;
  logic [SLOT_W-1:0] st_slot;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  key_t              wr_val;
  logic              clr_all;
  logic              start_rep;

  logic [CNT_W-1:0]  tab_off;
  key_t              emit_byte;
  logic              emit_last;

  assign out_free  = !o_valid || rsp.ready;
  assign cmd.ready = !busy && out_free;
  assign accept    = cmd.valid && cmd.ready;

  assign rsp.valid       = o_valid;
  assign rsp.is_report   = o_is_report;
  assign rsp.ok          = o_ok;
  assign rsp.slot        = o_slot;
  assign rsp.report_byte = o_byte;
  assign rsp.last        = o_last;

  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) begin
      hit[i]   = (slots[i] == cmd.key_code);
      empty[i] = (slots[i] == '0);
    end
  end

  assign hit_s   = first_set(hit);
  assign empty_s = first_set(empty);

  always_comb begin
    st_valid  = 1'b0;
    st_ok     = 1'b0;
    st_slot   = '0;
    wr_en     = 1'b0;
    wr_idx    = '0;
    wr_val    = cmd.key_code;
    clr_all   = 1'b0;
    start_rep = 1'b0;
    unique case (cmd.action) inside
      ACT_ADD: begin
        st_valid = 1'b1;
        // A present key is refused, and so is a full table.
        if (!hit_s.found && empty_s.found) begin
          st_ok   = 1'b1;
          st_slot = empty_s.idx;
          wr_en   = 1'b1;
          wr_idx  = empty_s.idx[IDX_W-1:0];
        end
      end
      ACT_REMOVE: begin
        st_valid = 1'b1;
        if (hit_s.found) begin
          st_ok   = 1'b1;
          st_slot = hit_s.idx;
          wr_en   = 1'b1;
          wr_idx  = hit_s.idx[IDX_W-1:0];
          wr_val  = '0;
        end
      end
      ACT_LOOKUP: begin
        st_valid = 1'b1;
        st_ok    = hit_s.found;
        st_slot  = hit_s.found ? hit_s.idx : '0;
      end
      ACT_CLEAR: begin
        st_valid = 1'b1;
        st_ok    = 1'b1;
        clr_all  = 1'b1;
      end
      ACT_SEND_TABLE, ACT_SEND_SINGLE: begin
        start_rep = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Report byte at position cnt. The table cannot change while a report
  // is streaming, so slots are read in place.
  assign tab_off = cnt - CNT_W'(KEY_POS);

  always_comb begin
    if (is_single) begin
      emit_byte = (cnt == CNT_W'(KEY_POS)) ? single_key : '0;
      emit_last = (cnt == CNT_W'(SINGLE_LEN - 1));
    end else begin
      emit_byte = (cnt < CNT_W'(KEY_POS)) ? '0 : slots[tab_off[IDX_W-1:0]];
      emit_last = (cnt == CNT_W'(TABLE_LEN - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      o_valid <= 1'b0;
      for (int i = 0; i < MAX_KEYS; i++) begin
        slots[i] <= '0;
      end
    end else begin
      if (busy && out_free) begin
        o_valid     <= 1'b1;
        o_is_report <= 1'b1;
        o_ok        <= 1'b0;
        o_slot      <= '0;
        o_byte      <= emit_byte;
        o_last      <= emit_last;
        cnt         <= cnt + CNT_W'(1);
        if (emit_last) begin
          busy <= 1'b0;
        end
      end else if (accept) begin
        o_valid <= st_valid || start_rep;
        if (wr_en) begin
          slots[wr_idx] <= wr_val;
        end
        if (clr_all) begin
          for (int i = 0; i < MAX_KEYS; i++) begin
            slots[i] <= '0;
          end
        end
        if (st_valid) begin
          o_is_report <= 1'b0;
          o_ok        <= st_ok;
          o_slot      <= st_slot;
          o_byte      <= '0;
          o_last      <= 1'b1;
        end
        if (start_rep) begin
          // First byte of either report is zero; the rest follow from cnt.
          o_is_report <= 1'b1;
          o_ok        <= 1'b0;
          o_slot      <= '0;
          o_byte      <= '0;
          o_last      <= 1'b0;
          busy        <= 1'b1;
          cnt         <= CNT_W'(1);
          is_single   <= (cmd.action == ACT_SEND_SINGLE);
          single_key  <= cmd.key_code;
        end
      end else if (out_free) begin
        o_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hkrt_checker.sv @@
// ----------------------------------------------------------------------------
// hkrt_checker
// Port-level checks of the key rollover table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrt_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      cmd_valid,
  input wire                      cmd_ready,
  input wire [hkrt_pkg::ACTION_W-1:0] cmd_action,
  input wire                      rsp_valid,
  input wire                      rsp_ready,
  input wire                      rsp_is_report,
  input wire                      rsp_ok,
  input wire [hkrt_pkg::SLOT_W-1:0] rsp_slot,
  input wire [hkrt_pkg::KEY_W-1:0]  rsp_report_byte,
  input wire                      rsp_last
);
  import hkrt_pkg::*;

  // A stalled result word holds still.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_is_report, rsp_ok, rsp_slot, rsp_report_byte, rsp_last}))
    else $error("result word changed while stalled");

  // Status words are single, carry no byte, and a failure names slot zero.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_is_report |->
      rsp_last && rsp_report_byte == '0 && (rsp_ok || rsp_slot == '0))
    else $error("malformed status word");

  a_report_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_report |-> !rsp_ok && rsp_slot == '0)
    else $error("report word carries status fields");

  // Once a report starts streaming, commands are held off.
  a_report_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready &&
      (cmd_action == ACT_SEND_TABLE || cmd_action == ACT_SEND_SINGLE)
      |=> !cmd_ready)
    else $error("command accepted during report");

endmodule

bind hid_key_rollover_table hkrt_checker u_hkrt_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_action      (cmd.action),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_is_report   (rsp.is_report),
  .rsp_ok          (rsp.ok),
  .rsp_slot        (rsp.slot),
  .rsp_report_byte (rsp.report_byte),
  .rsp_last        (rsp.last)
);

`default_nettype wire

@@ sim/tb_hid_key_rollover_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hid_key_rollover_table
// Self-checking bench for the key rollover table and its report output.
// Commands go in through the command channel with random gaps. Result
// words are taken with random stalls. A behavioral copy of the table
// predicts every status and report word, and the bench compares each one
// field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hid_key_rollover_table;
  import hkrt_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_WAIT       = 15;

  // Action codes that the block takes and drops.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              is_report;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    key_t              report_byte;
    logic              last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst;

  hkrt_cmd_if cmd ();
  hkrt_rsp_if rsp ();

  hid_key_rollover_table u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  key_t         held_keys [MAX_KEYS];
  result_word_t awaited_words [$];
  int           error_count  = 0;
  int           idle_cycles  = 0;
  bit           send_paced   = 1'b1;
  bit           recv_paced   = 1'b1;

  function automatic int draw_wait(bit paced);
    return paced ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  // Lowest slot holding the code; MAX_KEYS when no slot matches.
  function automatic int find_key(key_t key);
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (held_keys[i] == key) begin
        return i;
      end
    end
    return MAX_KEYS;
  endfunction

  function automatic void push_status(bit ok, int slot);
    result_word_t w;
    w      = '0;
    w.ok   = ok;
    w.slot = ok ? SLOT_W'(slot) : '0;
    w.last = 1'b1;
    awaited_words.push_back(w);
  endfunction

  function automatic void push_report_byte(key_t b, bit last);
    result_word_t w;
    w             = '0;
    w.is_report   = 1'b1;
    w.report_byte = b;
    w.last        = last;
    awaited_words.push_back(w);
  endfunction

  function automatic void predict_table_action(logic [ACTION_W-1:0] act, key_t key);
    int s;
    case (act)
      ACT_ADD: begin
        if (find_key(key) != MAX_KEYS) begin
          push_status(1'b0, 0);
        end else begin
          s = find_key('0);
          if (s == MAX_KEYS) begin
            push_status(1'b0, 0);
          end else begin
            held_keys[s] = key;
            push_status(1'b1, s);
          end
        end
      end
      ACT_REMOVE: begin
        s = find_key(key);
        if (s == MAX_KEYS) begin
          push_status(1'b0, 0);
        end else begin
          held_keys[s] = '0;
          push_status(1'b1, s);
        end
      end
      ACT_LOOKUP: begin
        s = find_key(key);
        push_status(s != MAX_KEYS, s);
      end
      ACT_CLEAR: begin
        foreach (held_keys[i]) held_keys[i] = '0;
        push_status(1'b1, 0);
      end
      ACT_SEND_TABLE: begin
        for (int k = 0; k < TABLE_LEN; k++) begin
          if (k < KEY_POS) begin
            push_report_byte('0, 1'b0);
          end else begin
            push_report_byte(held_keys[k - KEY_POS], k == TABLE_LEN - 1);
          end
        end
      end
      ACT_SEND_SINGLE: begin
        for (int k = 0; k < SINGLE_LEN; k++) begin
          push_report_byte((k == KEY_POS) ? key : key_t'(0), k == SINGLE_LEN - 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Valid stays high from one word to the next when there is no gap, so it
  // is never lowered and raised within the same time step.
  task automatic issue_command(logic [ACTION_W-1:0] act, key_t key);
    int gap;
    gap = draw_wait(send_paced);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.action   <= act;
    cmd.key_code <= key;
    do @(posedge clk); while (!cmd.ready);
    predict_table_action(act, key);
  endtask

  task automatic random_command(output bit counted);
    int            pick;
    logic [ACTION_W-1:0] act;
    key_t          key;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      key = key_t'($urandom_range(1, 10));
    end else if (pick < 80) begin
      key = '0;
    end else begin
      key = key_t'($urandom);
    end
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 32) begin
      act = ACT_ADD;
    end else if (pick < 52) begin
      act = ACT_REMOVE;
    end else if (pick < 67) begin
      act = ACT_LOOKUP;
    end else if (pick < 71) begin
      act = ACT_CLEAR;
    end else if (pick < 81) begin
      act = ACT_SEND_TABLE;
    end else if (pick < 91) begin
      act = ACT_SEND_SINGLE;
    end else begin
      act     = pick[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
      counted = 1'b0;
    end
    issue_command(act, key);
  endtask

  task automatic run_random(int count);
    int done;
    bit counted;
    done = 0;
    while (done < count) begin
      random_command(counted);
      if (counted) done++;
    end
  endtask

  task automatic test_status_cases();
    issue_command(ACT_LOOKUP, 8'h00);
    issue_command(ACT_REMOVE, 8'h00);
    issue_command(ACT_ADD,    8'h00);
    issue_command(ACT_ADD,    8'hFF);
    issue_command(ACT_ADD,    8'h01);
    issue_command(ACT_ADD,    8'hFF);
    issue_command(ACT_LOOKUP, 8'h01);
    issue_command(ACT_LOOKUP, 8'h80);
    issue_command(ACT_REMOVE, 8'h80);
    issue_command(ACT_REMOVE, 8'hFF);
    issue_command(ACT_LOOKUP, 8'h00);
    issue_command(ACT_ADD,    8'h80);
    issue_command(ACT_ADD,    8'h55);
    issue_command(ACT_ADD,    8'hAA);
    issue_command(ACT_ADD,    8'h04);
    issue_command(ACT_ADD,    8'h05);
    // The table is full from here on.
    issue_command(ACT_ADD,    8'h06);
    issue_command(ACT_ADD,    8'h00);
    issue_command(ACT_LOOKUP, 8'h00);
    issue_command(ACT_REMOVE, 8'h00);
    issue_command(ACT_SPARE_LO, 8'h55);
    issue_command(ACT_SPARE_HI, 8'hAA);
  endtask

  task automatic test_report_cases();
    issue_command(ACT_SEND_TABLE,  8'h00);
    issue_command(ACT_SEND_SINGLE, 8'hFF);
    issue_command(ACT_SEND_SINGLE, 8'h00);
    issue_command(ACT_CLEAR,       8'h00);
    issue_command(ACT_SEND_TABLE,  8'h00);
  endtask

  task automatic test_random_paced();
    send_paced = 1'b1;
    recv_paced = 1'b1;
    run_random(160);
  endtask

  task automatic test_random_full_rate();
    send_paced = 1'b0;
    recv_paced = 1'b0;
    run_random(60);
  endtask

  task automatic test_random_slow_sink();
    send_paced = 1'b0;
    recv_paced = 1'b1;
    run_random(50);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      int stall;
      stall = draw_wait(recv_paced);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_words.size() == 0) begin
        $error("result word with none expected: report %0b byte %0h",
               rsp.is_report, rsp.report_byte);
        error_count++;
      end else begin
        want = awaited_words.pop_front();
        check_field("is_report",   want.is_report,   rsp.is_report);
        check_field("ok",          want.ok,          rsp.ok);
        check_field("slot",        want.slot,        rsp.slot);
        check_field("report_byte", want.report_byte, rsp.report_byte);
        check_field("last",        want.last,        rsp.last);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cmd.valid    = 1'b0;
    cmd.action   = ACT_ADD;
    cmd.key_code = '0;
    foreach (held_keys[i]) held_keys[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_status_cases();
    test_report_cases();
    test_random_paced();
    test_random_full_rate();
    test_random_slow_sink();

    // The last command was taken at this edge; drop valid so it is not repeated.
    cmd.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
